>>> hw/rtl/fddf_pkg.sv
// Shared types and constants of the feedback delay distortion filter.
`timescale 1ns / 1ps

package fddf_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int COEF_W     = 8;
  localparam int LEN_W      = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DELTA  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 3'd4;

  localparam logic [COEF_W-1:0] ALPHA_RST  = 8'd0;
  localparam logic [COEF_W-1:0] BETA_RST   = 8'd64;
  localparam logic [COEF_W-1:0] DELTA_RST  = 8'd77;
  localparam logic [COEF_W-1:0] OFFSET_RST = 8'd64;
  localparam logic [LEN_W-1:0]  LENGTH_RST = 11'd200;

  // Datapath widths
  localparam int Y_W     = 18;  // Q2.16, clipped to +-1.0
  localparam int SQ_W    = 16;  // Q1.15 square
  localparam int ACC_W   = 30;  // Q.24 accumulator
  localparam int MUL_A_W = 25;
  localparam int MUL_B_W = 24;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int BLK_W   = 24;  // Q8.16 blocker state
  localparam int OUT_W   = 20;  // Q6.14 output

  localparam logic signed [Y_W-1:0]     Y_CLIP   = 18'sd65208;
  localparam logic signed [ACC_W-9:0]   Y_LIM    = 22'sd65536;
  localparam logic signed [MUL_A_W-1:0] POLE_Q24 = 25'sd16609444;
  localparam logic signed [BLK_W-1:0]   BLK_MAX  = 24'sd8388607;
  localparam logic signed [BLK_W-1:0]   BLK_MIN  = -24'sd8388608;
  localparam logic signed [OUT_W-1:0]   OUT_MAX  = 20'sd524287;
  localparam logic signed [OUT_W-1:0]   OUT_MIN  = -20'sd524288;

  // Multiplier operand select
  typedef enum logic [2:0] {
    MUL_NONE  = 3'd0,
    MUL_ALPHA = 3'd1,
    MUL_BETA  = 3'd2,
    MUL_DELTA = 3'd3,
    MUL_SQ    = 3'd4,
    MUL_POLE  = 3'd5
  } mul_sel_t;

  typedef enum logic [10:0] {
    ST_CLEAR = 11'b000_0000_0001,
    ST_IDLE  = 11'b000_0000_0010,
    ST_ALPHA = 11'b000_0000_0100,
    ST_BETA  = 11'b000_0000_1000,
    ST_DELTA = 11'b000_0001_0000,
    ST_ACC   = 11'b000_0010_0000,
    ST_ROUND = 11'b000_0100_0000,
    ST_SQ    = 11'b000_1000_0000,
    ST_POLE  = 11'b001_0000_0000,
    ST_BLK   = 11'b010_0000_0000,
    ST_OUT   = 11'b100_0000_0000
  } state_t;

  typedef struct packed {
    logic     accept;
    mul_sel_t mul_sel;
    logic     acc_add;
    logic     y_update;
    logic     ring_wr;
    logic     blk_update;
    logic     load_out;
    logic     clear_step;
  } fddf_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } fddf_sts_t;

endpackage

>>> hw/rtl/feedback_delay_distortion_filter.sv
// Top level of the feedback delay distortion filter (one audio channel).
`timescale 1ns / 1ps

// Usage:
//   Input channel: in_valid / in_stall / in_sample (signed Q1.15 at 16 bits).
//   A transaction completes on a clock edge with in_valid high and in_stall low.
//   Output channel: out_valid / out_stall / out_sample (signed Q6.14, saturated).
//   Exactly one output transaction follows every input transaction, in order.
//   Configuration: cfg_we / cfg_index / cfg_data write one register per cycle,
//   no wait states; write only while no sample is in flight.
// Timing:
//   One sample at a time. An accepted sample presents its result when its steps
//   are done and the output register is free; the input reopens in that same
//   cycle, so a new sample is taken only after the last result is loaded. The
//   steps are set by the single shared 25x24 multiplier, used for five products
//   in turn, plus accumulate, rounding and blocker steps.
// Reset (rst_n, synchronous, active low):
//   Registers take their defaults, then a clearing sweep zeroes the square ring,
//   one entry per cycle over RING_DEPTH entries (1024 by default), while in_stall
//   is held high. Configuration writes are taken during the sweep.
// Stall:
//   A held result stays in the output register; the block finishes the next
//   sample and then waits with in_stall high until the register is taken.

module feedback_delay_distortion_filter #(
  parameter int RING_DEPTH  = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [SAMPLE_BITS-1:0]        in_sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [fddf_pkg::OUT_W-1:0]    out_sample,
  input  logic                                 cfg_we,
  input  logic [fddf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fddf_pkg::CFG_DATA_W-1:0]      cfg_data
);

  fddf_pkg::fddf_cmd_t cmd;
  fddf_pkg::fddf_sts_t sts;

  // Sequencer: clearing sweep after reset, then the per-sample step order
  fddf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Arithmetic, ring of squares, blocker state and the output register
  fddf_datapath #(
    .RING_DEPTH  (RING_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_sample  (in_sample),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_sample (out_sample),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts)
  );

`ifndef SYNTHESIS
  // One sample in flight: an accepted transaction closes the input right after
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a sample is in flight");

  // Never overwrite a result that has not been taken
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid || !out_stall))
    else $error("output register overwritten while held");

  // A new result appears only from a load by the sequencer
  a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.load_out))
    else $error("output valid raised without a load");

  // No ring write of a square during the clearing sweep
  a_no_write_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_step |-> (!cmd.ring_wr && !cmd.accept))
    else $error("sample activity during ring clear");
`endif

endmodule

>>> hw/rtl/fddf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module fddf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/fddf_datapath.sv
// Datapath: configuration registers, shared multiplier, accumulator, ring and blocker.
`timescale 1ns / 1ps

module fddf_datapath #(
  parameter int RING_DEPTH  = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic signed [SAMPLE_BITS-1:0]         in_sample,
  input  logic                                  out_stall,
  output logic                                  out_valid,
  output logic signed [fddf_pkg::OUT_W-1:0]     out_sample,
  input  logic                                  cfg_we,
  input  logic [fddf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [fddf_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  fddf_pkg::fddf_cmd_t                   cmd,
  output fddf_pkg::fddf_sts_t                   sts
);

  localparam int ADDR_W = $clog2(RING_DEPTH);
  localparam int CMP_W  = (ADDR_W + 1 > fddf_pkg::LEN_W) ? ADDR_W + 1 : fddf_pkg::LEN_W;
  localparam int XSH    = 25 - SAMPLE_BITS;
  localparam int ACC_W  = fddf_pkg::ACC_W;
  localparam int Y_W    = fddf_pkg::Y_W;
  localparam int BLK_W  = fddf_pkg::BLK_W;
  localparam int OUT_W  = fddf_pkg::OUT_W;
  localparam int PROD_W = fddf_pkg::PROD_W;

  // Configuration
  logic [fddf_pkg::COEF_W-1:0] alpha_r, beta_r, delta_r, offset_r;
  logic [fddf_pkg::LEN_W-1:0]  length_r;

  // State
  logic [ADDR_W-1:0]       ring_pos_r, ring_pos_nxt;
  logic [ADDR_W-1:0]       clr_cnt_r;
  logic signed [Y_W-1:0]   y1_r, y2_r;
  logic signed [Y_W:0]     last_in_r;
  logic signed [BLK_W-1:0] last_out_r;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [OUT_W-1:0] res_r;
  logic                    out_valid_r;
  logic signed [OUT_W-1:0] out_sample_r;

  logic [fddf_pkg::SQ_W-1:0] tap;

  function automatic logic [CMP_W-1:0] len_in_use(input logic [fddf_pkg::LEN_W-1:0] dl);
    logic [CMP_W-1:0] v;
    v = CMP_W'(dl);
    if (v == '0) begin
      v = CMP_W'(1);
    end else if (v > CMP_W'(RING_DEPTH)) begin
      v = CMP_W'(RING_DEPTH);
    end
    return v;
  endfunction

  // Configuration writes and ring position
  logic [CMP_W-1:0] len_cur, len_new, pos_inc;
  assign len_cur = len_in_use(length_r);
  assign len_new = len_in_use(cfg_data[fddf_pkg::LEN_W-1:0]);
  assign pos_inc = CMP_W'(ring_pos_r) + CMP_W'(1);

  always_comb begin
    ring_pos_nxt = ring_pos_r;
    if (cmd.ring_wr) begin
      ring_pos_nxt = (pos_inc >= len_cur) ? '0 : pos_inc[ADDR_W-1:0];
    end else if (cfg_we && cfg_index == fddf_pkg::CFG_LENGTH) begin
      if (CMP_W'(ring_pos_r) >= len_new) begin
        ring_pos_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r    <= fddf_pkg::ALPHA_RST;
      beta_r     <= fddf_pkg::BETA_RST;
      delta_r    <= fddf_pkg::DELTA_RST;
      offset_r   <= fddf_pkg::OFFSET_RST;
      length_r   <= fddf_pkg::LENGTH_RST;
      ring_pos_r <= '0;
    end else begin
      ring_pos_r <= ring_pos_nxt;
      if (cfg_we) begin
        case (cfg_index)
          fddf_pkg::CFG_ALPHA:  alpha_r  <= cfg_data[fddf_pkg::COEF_W-1:0];
          fddf_pkg::CFG_BETA:   beta_r   <= cfg_data[fddf_pkg::COEF_W-1:0];
          fddf_pkg::CFG_DELTA:  delta_r  <= cfg_data[fddf_pkg::COEF_W-1:0];
          fddf_pkg::CFG_OFFSET: offset_r <= cfg_data[fddf_pkg::COEF_W-1:0];
          fddf_pkg::CFG_LENGTH: length_r <= cfg_data[fddf_pkg::LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Clearing sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear_step) begin
      clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
    end
  end
  assign sts.clear_last = (clr_cnt_r == ADDR_W'(RING_DEPTH - 1));

  // Shared multiplier
  logic signed [9:0]                     beta_m;
  logic [9:0]                            delta_p;
  logic signed [fddf_pkg::MUL_A_W-1:0]   mul_a;
  logic signed [fddf_pkg::MUL_B_W-1:0]   mul_b;

  assign beta_m  = $signed({2'b00, beta_r}) - 10'sd64;
  assign delta_p = {2'b00, delta_r} + 10'd128;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      fddf_pkg::MUL_ALPHA: begin
        mul_a = $signed({17'd0, alpha_r});
        mul_b = $signed({{6{y1_r[Y_W-1]}}, y1_r});
      end
      fddf_pkg::MUL_BETA: begin
        mul_a = $signed({{15{beta_m[9]}}, beta_m});
        mul_b = $signed({{6{y2_r[Y_W-1]}}, y2_r});
      end
      fddf_pkg::MUL_DELTA: begin
        mul_a = $signed({15'd0, delta_p});
        mul_b = $signed({8'd0, tap});
      end
      fddf_pkg::MUL_SQ: begin
        mul_a = $signed({{7{y1_r[Y_W-1]}}, y1_r});
        mul_b = $signed({{6{y1_r[Y_W-1]}}, y1_r});
      end
      fddf_pkg::MUL_POLE: begin
        mul_a = fddf_pkg::POLE_Q24;
        mul_b = last_out_r;
      end
      default: ;
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  // Accumulator for y in Q.24
  logic signed [ACC_W-1:0] x_ext, acc_init;
  assign x_ext    = $signed({{(ACC_W - SAMPLE_BITS){in_sample[SAMPLE_BITS-1]}}, in_sample}) <<< XSH;
  assign acc_init = x_ext - $signed({5'd0, offset_r, 17'd0});

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.accept) begin
      acc_nxt = acc_init;
    end else if (cmd.acc_add) begin
      acc_nxt = acc_r + $signed({prod_r[ACC_W-2:0], 1'b0});
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // Round to Q2.16 and clip
  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [ACC_W-9:0] y_wide;
  logic signed [Y_W-1:0]   y_clip;
  assign acc_rnd = acc_r + ACC_W'(128);
  assign y_wide  = $signed(acc_rnd[ACC_W-1:8]);

  always_comb begin
    if (y_wide > fddf_pkg::Y_LIM) begin
      y_clip = fddf_pkg::Y_CLIP;
    end else if (y_wide < -fddf_pkg::Y_LIM) begin
      y_clip = -fddf_pkg::Y_CLIP;
    end else begin
      y_clip = y_wide[Y_W-1:0];
    end
  end

  // Square of y for the ring, Q1.15 rounded
  logic [32:0]               sq_sum;
  logic [fddf_pkg::SQ_W-1:0] sq;
  assign sq_sum = prod_r[32:0] + 33'h0_0001_0000;
  assign sq     = sq_sum[32:17];

  // DC blocker
  logic signed [PROD_W-1:0] pole_rnd;
  logic signed [BLK_W:0]    pole_term;
  logic signed [BLK_W+2:0]  ny_wide;
  logic signed [BLK_W-1:0]  ny;
  logic signed [BLK_W:0]    o_sum;
  logic signed [BLK_W-2:0]  o_wide;
  logic signed [OUT_W-1:0]  o_clip;
  logic signed [Y_W:0]      yd;

  assign yd        = {y1_r, 1'b0};
  assign pole_rnd  = prod_r + PROD_W'(1 << 23);
  assign pole_term = $signed(pole_rnd[PROD_W-1:24]);
  assign ny_wide   = (BLK_W+3)'(yd) - (BLK_W+3)'(last_in_r) + (BLK_W+3)'(pole_term);

  always_comb begin
    if (ny_wide > (BLK_W+3)'(fddf_pkg::BLK_MAX)) begin
      ny = fddf_pkg::BLK_MAX;
    end else if (ny_wide < (BLK_W+3)'(fddf_pkg::BLK_MIN)) begin
      ny = fddf_pkg::BLK_MIN;
    end else begin
      ny = ny_wide[BLK_W-1:0];
    end
  end

  assign o_sum  = (BLK_W+1)'(ny) + (BLK_W+1)'(2);
  assign o_wide = $signed(o_sum[BLK_W:2]);

  always_comb begin
    if (o_wide > (BLK_W-1)'(fddf_pkg::OUT_MAX)) begin
      o_clip = fddf_pkg::OUT_MAX;
    end else if (o_wide < (BLK_W-1)'(fddf_pkg::OUT_MIN)) begin
      o_clip = fddf_pkg::OUT_MIN;
    end else begin
      o_clip = o_wide[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y1_r       <= '0;
      y2_r       <= '0;
      last_in_r  <= '0;
      last_out_r <= '0;
    end else begin
      if (cmd.y_update) begin
        y2_r <= y1_r;
        y1_r <= y_clip;
      end
      if (cmd.blk_update) begin
        last_in_r  <= yd;
        last_out_r <= ny;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.blk_update) begin
      res_r <= o_clip;
    end
  end

  // Ring of squares
  logic [ADDR_W-1:0]         ram_waddr;
  logic [fddf_pkg::SQ_W-1:0] ram_wdata;
  assign ram_waddr = cmd.clear_step ? clr_cnt_r : ring_pos_r;
  assign ram_wdata = cmd.clear_step ? '0 : sq;

  fddf_ram #(
    .WIDTH (fddf_pkg::SQ_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.clear_step | cmd.ring_wr),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.accept),
    .raddr (ring_pos_r),
    .rdata (tap)
  );

  // Output register
  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_sample_r <= res_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

endmodule

>>> hw/rtl/fddf_ctrl.sv
// Controller: sequences clearing sweep and the per-sample multiply steps.
`timescale 1ns / 1ps

module fddf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fddf_pkg::fddf_sts_t sts,
  output fddf_pkg::fddf_cmd_t cmd
);

  fddf_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fddf_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      fddf_pkg::ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_nxt = fddf_pkg::ST_IDLE;
        end
      end
      fddf_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = fddf_pkg::ST_ALPHA;
        end
      end
      fddf_pkg::ST_ALPHA: begin
        cmd.mul_sel = fddf_pkg::MUL_ALPHA;
        state_nxt   = fddf_pkg::ST_BETA;
      end
      fddf_pkg::ST_BETA: begin
        cmd.mul_sel = fddf_pkg::MUL_BETA;
        cmd.acc_add = 1'b1;
        state_nxt   = fddf_pkg::ST_DELTA;
      end
      fddf_pkg::ST_DELTA: begin
        cmd.mul_sel = fddf_pkg::MUL_DELTA;
        cmd.acc_add = 1'b1;
        state_nxt   = fddf_pkg::ST_ACC;
      end
      fddf_pkg::ST_ACC: begin
        cmd.acc_add = 1'b1;
        state_nxt   = fddf_pkg::ST_ROUND;
      end
      fddf_pkg::ST_ROUND: begin
        cmd.y_update = 1'b1;
        state_nxt    = fddf_pkg::ST_SQ;
      end
      fddf_pkg::ST_SQ: begin
        cmd.mul_sel = fddf_pkg::MUL_SQ;
        state_nxt   = fddf_pkg::ST_POLE;
      end
      fddf_pkg::ST_POLE: begin
        cmd.mul_sel = fddf_pkg::MUL_POLE;
        cmd.ring_wr = 1'b1;
        state_nxt   = fddf_pkg::ST_BLK;
      end
      fddf_pkg::ST_BLK: begin
        cmd.blk_update = 1'b1;
        state_nxt      = fddf_pkg::ST_OUT;
      end
      fddf_pkg::ST_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = fddf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fddf_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != fddf_pkg::ST_IDLE);

endmodule

>>> verif/tb_feedback_delay_distortion_filter.sv
// Self-checking testbench for the feedback delay distortion filter.
`timescale 1ns / 1ps

module tb_feedback_delay_distortion_filter;

  localparam int SMP_W         = 16;
  localparam int RING_N        = 1024;
  localparam int PHASE_ITEMS   = 166;
  localparam int RX_HOLD_LEN   = 400;   // long receiver hold-off, in cycles
  localparam int TAIL_CYCLES   = 40;    // settle time after the last result
  localparam int WDOG_LIMIT    = 6000;  // covers the ring clearing sweep

  // Fixed-point constants of the filter datapath
  localparam longint Y_LIMIT_Q16 = 65536;   // 1.0 in Q.16
  localparam longint Y_SAT_Q16   = 65208;   // 0.995 in Q.16
  localparam longint DC_POLE_Q24 = 16609444; // 0.99 in Q.24
  localparam longint DCB_HI      = 8388607;
  localparam longint DCB_LO      = -8388608;
  localparam longint PCM_HI      = 524287;
  localparam longint PCM_LO      = -524288;

  // Idle / stall profiles, one per random phase
  localparam int MODE_STEADY  = 0;
  localparam int MODE_TX_IDLE = 1;
  localparam int MODE_RX_STALL = 2;
  localparam int MODE_BOTH    = 3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic signed [SMP_W-1:0]             in_sample = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic signed [fddf_pkg::OUT_W-1:0]   out_sample;
  logic                                cfg_we = 1'b0;
  logic [fddf_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
  logic [fddf_pkg::CFG_DATA_W-1:0]     cfg_data = '0;

  // Transaction bookkeeping
  logic signed [SMP_W-1:0]           samples_pending[$];
  logic signed [fddf_pkg::OUT_W-1:0] pcm_expected[$];
  int  n_offered = 0;
  int  n_taken = 0;
  logic in_took = 1'b0;
  logic failed = 1'b0;
  int  in_idle_pct = 0;
  int  out_stall_pct = 0;
  int  rx_hold_req = 0;
  int  rx_hold_seen = 0;
  int  rx_hold_left = 0;
  int  quiet_cycles = 0;

  // Shadow copy of the filter state and its registers
  logic [fddf_pkg::COEF_W-1:0] alpha_c, beta_c, delta_c, offset_c;
  logic [fddf_pkg::LEN_W-1:0]  len_reg;
  longint                      y_last, y_prev, dcb_in, dcb_out;
  logic [fddf_pkg::SQ_W-1:0]   sq_ring[RING_N];
  int unsigned                 ring_at;

  feedback_delay_distortion_filter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_sample (in_sample),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_sample(out_sample),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Ring entries in use: zero acts as one, anything past the ring acts as the full ring.
  function automatic int unsigned ring_span();
    int unsigned n;
    n = len_reg;
    if (n < 1) n = 1;
    if (n > RING_N) n = RING_N;
    return n;
  endfunction

  // Advance the shadow filter by one sample and return the expected PCM output.
  function automatic logic signed [fddf_pkg::OUT_W-1:0] distort_step(
    logic signed [SMP_W-1:0] x);
    longint xs, acc, y, sq, y2, n, o;
    int unsigned pos;
    xs = x;
    if (ring_at >= ring_span()) ring_at = 0;
    pos = ring_at;

    // Sum all terms in Q.24, then round half up to Q.16
    acc = longint'(alpha_c) * y_last * 2;
    acc += (longint'(beta_c) - 64) * y_prev * 2;
    acc += (longint'(delta_c) + 128) * longint'(sq_ring[pos]) * 2;
    acc -= longint'(offset_c) * 131072;
    acc += xs * 512;
    y = (acc + 128) >>> 8;

    // Soft clip just inside full scale
    if (y > Y_LIMIT_Q16) y = Y_SAT_Q16;
    if (y < -Y_LIMIT_Q16) y = -Y_SAT_Q16;
    y_prev = y_last;
    y_last = y;

    // Store the Q1.15 square and step the ring
    sq = (y * y + 65536) >>> 17;
    sq_ring[pos] = sq[fddf_pkg::SQ_W-1:0];
    pos++;
    if (pos >= ring_span()) pos = 0;
    ring_at = pos;

    // DC blocker on 2y, state saturated to 24 bits
    y2 = y * 2;
    n = y2 - dcb_in + ((dcb_out * DC_POLE_Q24 + 64'sd8388608) >>> 24);
    if (n > DCB_HI) n = DCB_HI;
    if (n < DCB_LO) n = DCB_LO;
    dcb_in = y2;
    dcb_out = n;

    o = (n + 2) >>> 2;
    if (o > PCM_HI) o = PCM_HI;
    if (o < PCM_LO) o = PCM_LO;
    return o[fddf_pkg::OUT_W-1:0];
  endfunction

  // Sample mix: mostly full range and mid-level audio, some quiet passages and rails.
  function automatic logic signed [SMP_W-1:0] pick_sample();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(9))
      0: begin
        case (r[1:0])
          2'd0: return 16'sh8000;
          2'd1: return 16'sh7FFF;
          2'd2: return 16'sh0000;
          default: return 16'shFFFF;
        endcase
      end
      1, 2, 3, 4: return r[SMP_W-1:0];
      5, 6, 7: return SMP_W'($signed($urandom_range(8191)) - 4096);
      default: return SMP_W'($signed($urandom_range(32767)) - 16384);
    endcase
  endfunction

  // Write one register through the config port and mirror it in the shadow state.
  task automatic cfg_write(logic [fddf_pkg::CFG_IDX_W-1:0] idx,
                           logic [fddf_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      fddf_pkg::CFG_ALPHA:  alpha_c = val[fddf_pkg::COEF_W-1:0];
      fddf_pkg::CFG_BETA:   beta_c = val[fddf_pkg::COEF_W-1:0];
      fddf_pkg::CFG_DELTA:  delta_c = val[fddf_pkg::COEF_W-1:0];
      fddf_pkg::CFG_OFFSET: offset_c = val[fddf_pkg::COEF_W-1:0];
      fddf_pkg::CFG_LENGTH: begin
        len_reg = val[fddf_pkg::LEN_W-1:0];
        // Wrap the ring position if the new length cuts it off
        if (ring_at >= ring_span()) ring_at = 0;
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_coefs(int a, int b, int d, int c, int len);
    cfg_write(fddf_pkg::CFG_ALPHA, fddf_pkg::CFG_DATA_W'(a));
    cfg_write(fddf_pkg::CFG_BETA, fddf_pkg::CFG_DATA_W'(b));
    cfg_write(fddf_pkg::CFG_DELTA, fddf_pkg::CFG_DATA_W'(d));
    cfg_write(fddf_pkg::CFG_OFFSET, fddf_pkg::CFG_DATA_W'(c));
    cfg_write(fddf_pkg::CFG_LENGTH, fddf_pkg::CFG_DATA_W'(len));
  endtask

  task automatic queue_sample(logic signed [SMP_W-1:0] s);
    samples_pending.push_back(s);
    n_offered++;
  endtask

  // Hold the sender until every queued sample went in and every result came out.
  task automatic wait_drained();
    while (samples_pending.size() != 0 || n_taken != n_offered || pcm_expected.size() != 0)
      @(negedge clk);
  endtask

  // Input driver: drive at the falling edge, hold the payload until the transaction completes.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      // stalled: keep valid and sample unchanged
    end else if (samples_pending.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
      in_valid <= 1'b1;
      in_sample <= samples_pending.pop_front();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver stall driver: a requested long hold-off wins over random stalls.
  always @(negedge clk) begin
    if (rx_hold_req != rx_hold_seen) begin
      rx_hold_seen <= rx_hold_req;
      rx_hold_left <= RX_HOLD_LEN - 1;
      out_stall <= 1'b1;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < out_stall_pct);
    end
  end

  // Input monitor: predict the output of every accepted sample.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      pcm_expected.push_back(distort_step(in_sample));
      n_taken <= n_taken + 1;
      in_took <= 1'b1;
    end else begin
      in_took <= 1'b0;
    end
  end

  // Output monitor: compare every accepted result against the oldest prediction.
  always @(posedge clk) begin
    logic signed [fddf_pkg::OUT_W-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (pcm_expected.size() == 0) begin
        $display("%0t: unexpected out_sample, expected none, actual %0d", $time, out_sample);
        failed <= 1'b1;
      end else begin
        want = pcm_expected.pop_front();
        if (out_sample !== want) begin
          $display("%0t: out_sample mismatch, expected %0d, actual %0d",
                   $time, want, out_sample);
          failed <= 1'b1;
        end
      end
    end
  end

  // Watchdog: stop if no transaction moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    alpha_c = fddf_pkg::ALPHA_RST;
    beta_c = fddf_pkg::BETA_RST;
    delta_c = fddf_pkg::DELTA_RST;
    offset_c = fddf_pkg::OFFSET_RST;
    len_reg = fddf_pkg::LENGTH_RST;
    y_last = 0;
    y_prev = 0;
    dcb_in = 0;
    dcb_out = 0;
    ring_at = 0;
    foreach (sq_ring[i]) sq_ring[i] = '0;

    // Hold reset, then release it on a falling edge
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: rails and zero crossings under the reset coefficients
    queue_sample(16'sh7FFF);
    queue_sample(16'sh8000);
    queue_sample(16'sh0000);
    queue_sample(16'shFFFF);
    queue_sample(16'sh0001);
    wait_drained();

    // Directed: unity first feedback, no offset, so y integrates x into both clip rails
    cfg_write(fddf_pkg::CFG_ALPHA, fddf_pkg::CFG_DATA_W'(128));
    cfg_write(fddf_pkg::CFG_OFFSET, fddf_pkg::CFG_DATA_W'(0));
    repeat (8) queue_sample(16'sh7FFF);
    repeat (8) queue_sample(16'sh8000);
    wait_drained();

    // Random phases; each phase boundary pauses the sender until all results are in
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        // Maximum alpha code past the nominal range, three-entry ring
        0: load_coefs(255, 0, 0, 128, 3);
        // Length zero behaves as a one-entry ring
        1: load_coefs($urandom_range(128), $urandom_range(128), $urandom_range(128),
                      $urandom_range(128), 0);
        2: load_coefs(0, 255, 255, 255, RING_N);
        3: load_coefs($urandom_range(255), $urandom_range(255), $urandom_range(255),
                      $urandom_range(255), 1);
        // Length beyond the ring clamps to the full ring
        4: load_coefs(128, 128, 128, 0, 2047);
        // Shrinking the ring wraps the position back to the start
        5: load_coefs($urandom_range(128), $urandom_range(128), $urandom_range(128),
                      $urandom_range(128), 2);
        // Junk in the upper data bits of the 8-bit registers
        6: load_coefs($urandom_range(2047), $urandom_range(2047), $urandom_range(2047),
                      $urandom_range(2047), $urandom_range(3, 64));
        default: load_coefs($urandom_range(128), $urandom_range(128), $urandom_range(128),
                            $urandom_range(128), 200);
      endcase

      case (ph % 4)
        MODE_STEADY:   begin in_idle_pct = 0;  out_stall_pct = 0;  end
        MODE_TX_IDLE:  begin in_idle_pct = 54; out_stall_pct = 0;  end
        MODE_RX_STALL: begin in_idle_pct = 0;  out_stall_pct = 54; end
        default:       begin in_idle_pct = 11; out_stall_pct = 11; end
      endcase

      for (int k = 0; k < PHASE_ITEMS; k++) queue_sample(pick_sample());

      // Back-pressure: freeze the receiver while the sender keeps offering
      if (ph == 0) rx_hold_req++;
      wait_drained();
    end

    in_idle_pct = 0;
    out_stall_pct = 0;
    repeat (TAIL_CYCLES) @(negedge clk);

    if (!failed && pcm_expected.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      if (pcm_expected.size() != 0)
        $display("%0t: %0d expected results never arrived, expected 0, actual %0d",
                 $time, pcm_expected.size(), pcm_expected.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
